// ===== rtl/plfd_pkg.sv =====
// Shared types and constants for the preamble/length-prefixed frame deframer.
// No dependencies; used by the parser and the top level.
package plfd_pkg;

  // Default counter width for the field byte counter
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Preamble bytes 08 80 4D 53: first three live in the sliding window
  localparam logic [23:0] PREAMBLE_HEAD = 24'h08804D;
  localparam logic [7:0]  PREAMBLE_LAST = 8'h53;

  // Result word kinds
  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_WIDTH   = 8;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_TOPIC   = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_PAYLOAD = 8'd1;
  localparam logic [15:0] MAX_TOPIC_RST   = 16'd255;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  // One result word from the parser
  typedef struct packed {
    logic       valid;
    logic [1:0] item_kind;
    logic [7:0] item_byte;
    logic       field_last;
    logic       retain_flag;
  } result_t;

endpackage

// ===== rtl/plfd_rx_if.sv =====
// Input channel carrying one received byte per word.
// Depends on nothing; used by the top level.
interface plfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/plfd_item_if.sv =====
// Output channel carrying one deframed result word.
// Depends on nothing; used by the top level.
interface plfd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] item_byte;
  logic       field_last;
  logic       retain_flag;

  modport source (output valid, output item_kind, output item_byte,
                  output field_last, output retain_flag, input ready);
  modport sink   (input valid, input item_kind, input item_byte,
                  input field_last, input retain_flag, output ready);
endinterface

// ===== rtl/preamble_length_frame_deframer.sv =====
// Top level of the preamble/length-prefixed frame deframer.
// Depends on plfd_pkg, plfd_rx_if, plfd_item_if and plfd_parser.

// Takes one received byte per word on rx and delivers at most one result word
// per byte on item, in order. Every byte is processed by the parser state machine,
// and the result lands in one output register; a new byte is taken every cycle
// unless a held result is stalled by the sink, so the sustained rate is one byte
// per clock. Results are registered and appear in the cycle after the byte
// that causes them. A frame is preamble 08 80 4D 53, a 32-bit little-endian
// topic length, a 32-bit little-endian payload length, the topic bytes, the
// payload bytes, a QoS byte (dropped) and a retain byte (reported as a
// frame-end word). A length above its max register, or beyond the CountWidth
// counter, yields a length-error word and the block hunts again. The two max
// registers are written through cfg_*; write them only while the block is idle.
module preamble_length_frame_deframer #(
  parameter int unsigned CountWidth = plfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [plfd_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  plfd_rx_if.sink                            rx,
  plfd_item_if.source                        item
);

  logic [15:0]       max_topic_q;
  logic [15:0]       max_payload_q;
  logic              step;
  plfd_pkg::result_t res;
  logic              out_valid_q;
  logic [1:0]        out_kind_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              out_retain_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_topic_q   <= plfd_pkg::MAX_TOPIC_RST;
      max_payload_q <= plfd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == plfd_pkg::CFG_MAX_TOPIC) begin
        max_topic_q <= cfg_data_i;
      end
      if (cfg_index_i == plfd_pkg::CFG_MAX_PAYLOAD) begin
        max_payload_q <= cfg_data_i;
      end
    end
  end

  // Take a byte whenever the output register is free or draining
  assign rx.ready = !out_valid_q || item.ready;
  assign step     = rx.valid && rx.ready;

  plfd_parser #(
    .CountWidth (CountWidth)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (rx.rx_byte),
    .max_topic_i   (max_topic_q),
    .max_payload_i (max_payload_q),
    .result_o      (res)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.valid;
    end else if (item.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_kind_q   <= res.item_kind;
      out_byte_q   <= res.item_byte;
      out_last_q   <= res.field_last;
      out_retain_q <= res.retain_flag;
    end
  end

  assign item.valid       = out_valid_q;
  assign item.item_kind   = out_kind_q;
  assign item.item_byte   = out_byte_q;
  assign item.field_last  = out_last_q;
  assign item.retain_flag = out_retain_q;

endmodule

// ===== rtl/plfd_parser.sv =====
// Frame parser state machine: preamble hunt, length words, field bytes.
// Depends on plfd_pkg; instantiated by preamble_length_frame_deframer.
module plfd_parser #(
  parameter int unsigned CountWidth = plfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [15:0]       max_topic_i,
  input  logic [15:0]       max_payload_i,
  output plfd_pkg::result_t result_o
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TLEN    = 3'd1;
  localparam logic [2:0] PH_PLEN    = 3'd2;
  localparam logic [2:0] PH_TOPIC   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_QOS     = 3'd5;
  localparam logic [2:0] PH_RETAIN  = 3'd6;

  localparam logic [1:0] LAST_LANE = 2'd3;

  logic [2:0]            phase_q, phase_d;
  logic [23:0]           win_q, win_d;
  logic [1:0]            idx_q, idx_d;
  logic [31:0]           tlen_q, tlen_d;
  logic [31:0]           plen_q, plen_d;
  logic [CountWidth-1:0] rem_q, rem_d;
  logic                  last;

  // Next state and result for the byte at the input
  always_comb begin
    phase_d  = phase_q;
    win_d    = win_q;
    idx_d    = idx_q;
    tlen_d   = tlen_q;
    plen_d   = plen_q;
    rem_d    = rem_q;
    last     = (rem_q <= CountWidth'(1));
    result_o = '0;

    case (phase_q)
      PH_TLEN: begin
        tlen_d[{idx_q, 3'b000} +: 8] = rx_byte_i;
        if (idx_q == LAST_LANE) begin
          idx_d = '0;
          if ((tlen_d > {16'd0, max_topic_i}) || ((tlen_d >> CountWidth) != 32'd0)) begin
            phase_d            = PH_HUNT;
            win_d              = '0;
            rem_d              = '0;
            result_o.valid     = 1'b1;
            result_o.item_kind = plfd_pkg::KIND_ERROR;
          end else begin
            plen_d  = '0;
            phase_d = PH_PLEN;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end

      PH_PLEN: begin
        plen_d[{idx_q, 3'b000} +: 8] = rx_byte_i;
        if (idx_q == LAST_LANE) begin
          idx_d = '0;
          if ((plen_d > {16'd0, max_payload_i}) || ((plen_d >> CountWidth) != 32'd0)) begin
            phase_d            = PH_HUNT;
            win_d              = '0;
            rem_d              = '0;
            result_o.valid     = 1'b1;
            result_o.item_kind = plfd_pkg::KIND_ERROR;
          end else if (tlen_q != 32'd0) begin
            rem_d   = tlen_q[CountWidth-1:0];
            phase_d = PH_TOPIC;
          end else if (plen_d != 32'd0) begin
            rem_d   = plen_d[CountWidth-1:0];
            phase_d = PH_PAYLOAD;
          end else begin
            rem_d   = '0;
            phase_d = PH_QOS;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end

      PH_TOPIC: begin
        result_o.valid      = 1'b1;
        result_o.item_kind  = plfd_pkg::KIND_TOPIC;
        result_o.item_byte  = rx_byte_i;
        result_o.field_last = last;
        if (!last) begin
          rem_d = rem_q - CountWidth'(1);
        end else if (plen_q != 32'd0) begin
          rem_d   = plen_q[CountWidth-1:0];
          phase_d = PH_PAYLOAD;
        end else begin
          rem_d   = '0;
          phase_d = PH_QOS;
        end
      end

      PH_PAYLOAD: begin
        result_o.valid      = 1'b1;
        result_o.item_kind  = plfd_pkg::KIND_PAYLOAD;
        result_o.item_byte  = rx_byte_i;
        result_o.field_last = last;
        if (last) begin
          rem_d   = '0;
          phase_d = PH_QOS;
        end else begin
          rem_d = rem_q - CountWidth'(1);
        end
      end

      PH_QOS: begin
        phase_d = PH_RETAIN;
      end

      PH_RETAIN: begin
        phase_d              = PH_HUNT;
        win_d                = '0;
        idx_d                = '0;
        rem_d                = '0;
        result_o.valid       = 1'b1;
        result_o.item_kind   = plfd_pkg::KIND_END;
        result_o.retain_flag = |rx_byte_i;
      end

      PH_HUNT: begin
        if (win_q == plfd_pkg::PREAMBLE_HEAD && rx_byte_i == plfd_pkg::PREAMBLE_LAST) begin
          win_d   = '0;
          idx_d   = '0;
          tlen_d  = '0;
          phase_d = PH_TLEN;
        end else begin
          win_d = {win_q[15:0], rx_byte_i};
        end
      end

      default: begin
        // unused code: back to hunting, no result
        phase_d = PH_HUNT;
        win_d   = '0;
        idx_d   = '0;
        rem_d   = '0;
      end
    endcase

    // no byte this cycle: nothing moves
    if (!step_i) begin
      result_o.valid = 1'b0;
    end
  end

  // Parser state, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= '0;
      idx_q   <= '0;
      tlen_q  <= '0;
      plen_q  <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      idx_q   <= idx_d;
      tlen_q  <= tlen_d;
      plen_q  <= plen_d;
      rem_q   <= rem_d;
    end
  end

endmodule
